// ----- hw/rtl/rstp_pkg.sv -----
package rstp_pkg;

  localparam int PKG_MAX_TILES     = 8192;
  localparam int PKG_MAX_TILE_EDGE = 32;

  localparam int CFG_DATA_W  = 21;
  localparam int CFG_INDEX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_EDGE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TILE_TOTAL  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DATA_LIMIT  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY    = 2'd3;

  // Tile edge codes.
  localparam logic [1:0] EDGE_8       = 2'd0;
  localparam logic [1:0] EDGE_16      = 2'd1;
  localparam logic [1:0] EDGE_32      = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [1:0]  RST_TILE_EDGE  = EDGE_16;
  localparam logic [13:0] RST_TILE_TOTAL = 14'd4220;
  localparam logic [20:0] RST_DATA_LIMIT = 21'd196608;
  localparam logic [19:0] RST_CAPACITY   = 20'd1048575;

  // Palette prefix in front of the tile directory, in words.
  localparam logic [14:0] PALETTE_WORDS = 15'd256;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_OVERFLOW = 2'd1,
    STATUS_CAPACITY = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  tile_edge_code;
    logic [13:0] tile_total;
    logic [20:0] data_limit_bytes;
    logic [19:0] capacity_words;
  } cfg_t;

  // Per-item result of the tile sequencer, plus what frame closing needs.
  typedef struct packed {
    logic [7:0]  pixel_code;
    logic [19:0] data_address;
    logic        write_enable;
    logic        tile_end;
    logic [12:0] tile_number;
    logic [31:0] directory_entry;
    logic        frame_end;
    logic [13:0] active_tiles;
    logic        cfg_err;
    logic        overflow;
    logic [20:0] bytes_used;
    logic [14:0] prefix_words;
  } seq_res_t;

endpackage

// ----- hw/rtl/rstp_if.sv -----
interface rstp_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rstp_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  pixel_code;
  logic [19:0] data_address;
  logic        write_enable;
  logic        tile_end;
  logic [12:0] tile_number;
  logic [31:0] directory_entry;
  logic        frame_end;
  logic [1:0]  status;
  logic [13:0] active_tiles;
  logic [19:0] total_words;

  modport source (
    output valid, pixel_code, data_address, write_enable, tile_end, tile_number,
           directory_entry, frame_end, status, active_tiles, total_words,
    input  ready
  );
  modport sink (
    input  valid, pixel_code, data_address, write_enable, tile_end, tile_number,
           directory_entry, frame_end, status, active_tiles, total_words,
    output ready
  );
endinterface

// ----- hw/rtl/rstp_tile_seq.sv -----
module rstp_tile_seq import rstp_pkg::*; #(
  parameter int MAX_TILES     = PKG_MAX_TILES,
  parameter int MAX_TILE_EDGE = PKG_MAX_TILE_EDGE
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       take,
  input  logic [7:0] code,
  output seq_res_t   res
);

  localparam logic [16:0] MaxTilesW = 17'(MAX_TILES);

  logic [9:0]  cell_cnt_r, cell_cnt_nxt;
  logic [12:0] tile_cnt_r, tile_cnt_nxt;
  logic [20:0] bytes_r, bytes_nxt;
  logic        nz_r, nz_nxt;
  logic [13:0] active_r, active_nxt;
  logic        ovf_r, ovf_nxt;

  logic        bad_edge;
  logic [10:0] cells;
  logic [9:0]  cells_m1;
  logic [13:0] tiles;
  logic [14:0] prefix;
  logic        cfg_err;
  logic        fits;
  logic        nz;
  logic [20:0] bytes_upd;
  logic        ovf_upd;

  always_comb begin
    bad_edge = 1'b0;
    cells    = 11'd64;
    case (cfg.tile_edge_code)
      EDGE_8:  cells = 11'd64;
      EDGE_16: begin
        cells    = 11'd256;
        bad_edge = (16 > MAX_TILE_EDGE);
      end
      EDGE_32: begin
        cells    = 11'd1024;
        bad_edge = (32 > MAX_TILE_EDGE);
      end
      default: bad_edge = 1'b1;
    endcase
    // An unusable edge still sequences the stream as 8x8 tiles.
    if (bad_edge) begin
      cells = 11'd64;
    end
    cells_m1 = 10'(cells - 11'd1);

    tiles = (cfg.tile_total == 14'd0) ? 14'd1 : cfg.tile_total;
    if ({3'b000, tiles} > MaxTilesW) begin
      tiles = 14'(MAX_TILES);
    end
    prefix  = PALETTE_WORDS + {1'b0, tiles};
    cfg_err = bad_edge ||
              ({1'b0, cfg.capacity_words} < (21'(prefix) + 21'd16));
  end

  always_comb begin
    nz   = nz_r || (code != 8'd0);
    fits = ({1'b0, bytes_r} + {11'd0, cells}) <= {1'b0, cfg.data_limit_bytes};

    res.pixel_code      = code;
    res.data_address    = 20'(bytes_r + {11'd0, cell_cnt_r});
    res.write_enable    = !cfg_err && !ovf_r && fits;
    res.tile_end        = (cell_cnt_r >= cells_m1);
    res.tile_number     = tile_cnt_r;
    res.directory_entry = 32'd0;
    res.frame_end       = 1'b0;
    res.cfg_err         = cfg_err;
    res.prefix_words    = prefix;

    bytes_upd    = bytes_r;
    ovf_upd      = ovf_r;
    active_nxt   = active_r;
    nz_nxt       = nz;
    cell_cnt_nxt = cell_cnt_r + 10'd1;
    tile_cnt_nxt = tile_cnt_r;

    if (res.tile_end) begin
      res.directory_entry = '1;
      if (nz && !ovf_r) begin
        if (!fits) begin
          ovf_upd = 1'b1;
        end else begin
          res.directory_entry = {11'd0, bytes_r};
          bytes_upd  = bytes_r + {10'd0, cells};
          active_nxt = active_r + 14'd1;
        end
      end
      nz_nxt        = 1'b0;
      cell_cnt_nxt  = '0;
      res.frame_end = ({1'b0, tile_cnt_r} >= (tiles - 14'd1));
      tile_cnt_nxt  = tile_cnt_r + 13'd1;
    end

    res.active_tiles = active_nxt;
    res.overflow     = ovf_upd;
    res.bytes_used   = bytes_upd;
    bytes_nxt        = bytes_upd;
    ovf_nxt          = ovf_upd;

    // A frame end returns every counter to zero for the next frame.
    if (res.frame_end) begin
      cell_cnt_nxt = '0;
      tile_cnt_nxt = '0;
      bytes_nxt    = '0;
      nz_nxt       = 1'b0;
      active_nxt   = '0;
      ovf_nxt      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_cnt_r <= '0;
      tile_cnt_r <= '0;
      bytes_r    <= '0;
      nz_r       <= 1'b0;
      active_r   <= '0;
      ovf_r      <= 1'b0;
    end else if (take) begin
      cell_cnt_r <= cell_cnt_nxt;
      tile_cnt_r <= tile_cnt_nxt;
      bytes_r    <= bytes_nxt;
      nz_r       <= nz_nxt;
      active_r   <= active_nxt;
      ovf_r      <= ovf_nxt;
    end
  end

endmodule

// ----- hw/rtl/rgb332_sparse_tile_packer.sv -----
// RGB332 sparse tile packer.
//
// Pixels enter on in_pix in tile order, one item per pixel, and each one
// leaves as one item on out_res: its RGB332 code, the byte address the code
// goes to in the packed data area, a write enable, and tile and frame
// bookkeeping. On the last pixel of a tile the item carries the tile's
// directory entry; on the last pixel of a frame it carries the status and the
// padded total word count, which is zero unless the status is OK.
// Items pass the input, counter and output registers. Throughput is one item
// per cycle while out_res.ready is high; the single-cycle limit is the offset
// loop adding the tile size to the running byte count and checking the data limit.
// The configuration port (cfg_we, cfg_index, cfg_wdata) writes one register
// per cycle and is meant to be used only while the pipeline is empty.
// Reset (rst_n low at a clock edge) empties the pipeline, clears all tile
// and frame counters and loads the default configuration.
// When the receiver holds out_res.ready low, items fill the three stages
// and then in_pix.ready drops; nothing is lost or repeated.
module rgb332_sparse_tile_packer import rstp_pkg::*; #(
  parameter int MAX_TILES     = PKG_MAX_TILES,
  parameter int MAX_TILE_EDGE = PKG_MAX_TILE_EDGE
) (
  input  logic                   clk,
  input  logic                   rst_n,
  rstp_pixel_if.sink             in_pix,
  rstp_result_if.source          out_res,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  cfg_t cfg_r;

  // Stage valid bits and the ready chain back from the output.
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  logic [7:0] code_r;
  seq_res_t   seq_res;
  seq_res_t   s2_r;

  logic [21:0] padded;
  logic [21:0] words;
  status_t     status;
  logic [19:0] total;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tile_edge_code   <= RST_TILE_EDGE;
      cfg_r.tile_total       <= RST_TILE_TOTAL;
      cfg_r.data_limit_bytes <= RST_DATA_LIMIT;
      cfg_r.capacity_words   <= RST_CAPACITY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TILE_EDGE:  cfg_r.tile_edge_code   <= cfg_wdata[1:0];
        CFG_TILE_TOTAL: cfg_r.tile_total       <= cfg_wdata[13:0];
        CFG_DATA_LIMIT: cfg_r.data_limit_bytes <= cfg_wdata[20:0];
        CFG_CAPACITY:   cfg_r.capacity_words   <= cfg_wdata[19:0];
        default:        ;
      endcase
    end
  end

  assign rdy3 = !v3_r || out_res.ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_pix.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_pix.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Stage 1: quantize straight into the input register.
  always_ff @(posedge clk) begin
    if (rdy1 && in_pix.valid) begin
      code_r <= {in_pix.red[7:5], in_pix.green[7:5], in_pix.blue[7:6]};
    end
  end

  // Stage 2: tile and frame counters advance as the item moves on.
  rstp_tile_seq #(
    .MAX_TILES     (MAX_TILES),
    .MAX_TILE_EDGE (MAX_TILE_EDGE)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .take  (v1_r && rdy2),
    .code  (code_r),
    .res   (seq_res)
  );

  always_ff @(posedge clk) begin
    if (v1_r && rdy2) begin
      s2_r <= seq_res;
    end
  end

  // Stage 3: frame closing. Data is padded to 64 bytes, and the prefix plus
  // the data words is rounded up to 16 words.
  always_comb begin
    padded = ({1'b0, s2_r.bytes_used} + 22'd63) & ~22'd63;
    words  = (22'(s2_r.prefix_words) + {2'b00, padded[21:2]} + 22'd15) & ~22'd15;
    status = STATUS_OK;
    total  = '0;
    if (s2_r.frame_end) begin
      if (s2_r.cfg_err) begin
        status = STATUS_CAPACITY;
      end else if (s2_r.overflow) begin
        status = STATUS_OVERFLOW;
      end else if (words > {2'b00, cfg_r.capacity_words}) begin
        status = STATUS_CAPACITY;
      end else begin
        total = words[19:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      out_res.pixel_code      <= s2_r.pixel_code;
      out_res.data_address    <= s2_r.data_address;
      out_res.write_enable    <= s2_r.write_enable;
      out_res.tile_end        <= s2_r.tile_end;
      out_res.tile_number     <= s2_r.tile_number;
      out_res.directory_entry <= s2_r.directory_entry;
      out_res.frame_end       <= s2_r.frame_end;
      out_res.status          <= status;
      out_res.active_tiles    <= s2_r.active_tiles;
      out_res.total_words     <= total;
    end
  end

  assign out_res.valid = v3_r;

endmodule
